// ===== rtl/core/rida_pkg.sv =====
// Shared constants, codes and interface types of the reference-counted ID allocator.
`timescale 1ns / 1ps
`default_nettype none
package rida_pkg;

  // Sizes
  localparam int unsigned ID_BITS    = 10;
  localparam int unsigned COUNT_BITS = 8;
  localparam int unsigned ID_SPACE   = 1 << ID_BITS;
  localparam int unsigned TDATA_W    = ((ID_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_ZERO = '0;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_TWO  = COUNT_BITS'(2);

  // Operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_ADDREF  = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  // Status codes returned with each result
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_IDS     = 2'd1,
    ST_STACK_FULL = 2'd2,
    ST_SATURATED  = 2'd3
  } status_e;

  // Operands gathered for one request after the memory reads
  typedef struct packed {
    logic [1:0]            op;
    logic [ID_BITS-1:0]    id;
    logic [COUNT_BITS-1:0] count;
    logic [ID_BITS-1:0]    top_id;
    logic [ID_BITS:0]      fill;
    logic [ID_BITS:0]      fresh;
  } exec_in_t;

  // Decision for one request: result word and state updates
  typedef struct packed {
    logic [ID_BITS-1:0]    res_id;
    logic                  freed;
    status_e               status;
    logic                  cnt_we;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic                  push;
    logic                  pop;
    logic                  fresh_inc;
  } exec_out_t;

endpackage
`default_nettype wire

// ===== rtl/core/refcounted_id_allocator.sv =====
// Top level: reference-counted ID allocator with a LIFO free stack in block memory.
//
//  Channel  Dir  tdata bits (low first)        tuser bits (low first)
//  s_axis   in   [9:0] id, [15:10] zero         [1:0] operation
//  m_axis   out  [9:0] result_id, [15:10] zero  [0] id_freed, [2:1] status
//
// Each word is accepted in the idle state, which launches the count-table and
// free-stack reads; the execute state then modifies, writes back and loads the
// output register, so a new word is not taken before the last one executes.
// After reset a clearing pass zeroes the count table, one entry a cycle,
// with s_axis_tready_o low. A stalled output holds the request in its
// execute state; a new word is taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_id_allocator (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  wire [rida_pkg::TDATA_W-1:0]  s_axis_tdata_i,   // id, zero fill
  input  wire [1:0]                    s_axis_tuser_i,   // operation
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  output logic [rida_pkg::TDATA_W-1:0] m_axis_tdata_o,   // result_id, zero fill
  output logic [2:0]                   m_axis_tuser_o    // id_freed, status
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  logic [rida_pkg::ID_BITS-1:0]    clr_q;
  logic [rida_pkg::ID_BITS:0]      fill_q;
  logic [rida_pkg::ID_BITS:0]      fresh_q;
  logic [1:0]                      op_q;
  logic [rida_pkg::ID_BITS-1:0]    id_q;
  logic                            out_valid_q;
  logic [rida_pkg::ID_BITS-1:0]    out_id_q;
  logic                            out_freed_q;
  logic [1:0]                      out_status_q;

  logic [rida_pkg::COUNT_BITS-1:0] cnt_mem [rida_pkg::ID_SPACE];
  logic [rida_pkg::ID_BITS-1:0]    stack_mem [rida_pkg::ID_SPACE];
  logic [rida_pkg::COUNT_BITS-1:0] cnt_rd_q;
  logic [rida_pkg::ID_BITS-1:0]    stack_rd_q;

  logic                            accept;
  logic                            fire;
  logic [rida_pkg::ID_BITS-1:0]    in_id;
  logic [rida_pkg::ID_BITS:0]      fill_dec;
  logic                            cnt_we;
  logic [rida_pkg::ID_BITS-1:0]    cnt_waddr;
  logic [rida_pkg::COUNT_BITS-1:0] cnt_wdata;
  rida_pkg::exec_in_t              exec_in;
  rida_pkg::exec_out_t             exec_out;

  // Handshake
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign fire            = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready_i);
  assign in_id           = s_axis_tdata_i[rida_pkg::ID_BITS-1:0];
  assign fill_dec        = fill_q - 1'b1;

  // Decide on the fetched operands
  always_comb begin
    exec_in.op     = op_q;
    exec_in.id     = id_q;
    exec_in.count  = cnt_rd_q;
    exec_in.top_id = stack_rd_q;
    exec_in.fill   = fill_q;
    exec_in.fresh  = fresh_q;
  end

  rida_decide u_decide (
    .exec_i (exec_in),
    .exec_o (exec_out)
  );

  // Count table write port: clearing pass or write-back
  always_comb begin
    if (state_q == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      cnt_wdata = rida_pkg::COUNT_ZERO;
    end else begin
      cnt_we    = fire && exec_out.cnt_we;
      cnt_waddr = id_q;
      cnt_wdata = exec_out.cnt_wdata;
    end
  end

  // Count table
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (accept) begin
      cnt_rd_q <= cnt_mem[in_id];
    end
  end

  // Free stack: push at fill, read the top at fill - 1
  always_ff @(posedge clk_i) begin
    if (fire && exec_out.push) begin
      stack_mem[fill_q[rida_pkg::ID_BITS-1:0]] <= id_q;
    end
    if (accept) begin
      stack_rd_q <= stack_mem[fill_dec[rida_pkg::ID_BITS-1:0]];
    end
  end

  // Request latch, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= s_axis_tuser_i;
      id_q <= in_id;
    end
  end

  // Sequencer, stack pointer, fresh counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      fill_q       <= '0;
      fresh_q      <= '0;
      out_valid_q  <= 1'b0;
      out_id_q     <= '0;
      out_freed_q  <= 1'b0;
      out_status_q <= '0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (m_axis_tvalid_o && m_axis_tready_i && !fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == {rida_pkg::ID_BITS{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_q      <= S_IDLE;
            out_valid_q  <= 1'b1;
            out_id_q     <= exec_out.res_id;
            out_freed_q  <= exec_out.freed;
            out_status_q <= exec_out.status;
            if (exec_out.push) begin
              fill_q <= fill_q + 1'b1;
            end else if (exec_out.pop) begin
              fill_q <= fill_dec;
            end
            if (exec_out.fresh_inc) begin
              fresh_q <= fresh_q + 1'b1;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Result word
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = rida_pkg::TDATA_W'(out_id_q);
  assign m_axis_tuser_o  = {out_status_q, out_freed_q};

endmodule
`default_nettype wire

// ===== rtl/core/rida_decide.sv =====
// Request decode: allocate, add-reference and release decisions from the fetched state.
`timescale 1ns / 1ps
`default_nettype none
module rida_decide (
  input  rida_pkg::exec_in_t  exec_i,
  output rida_pkg::exec_out_t exec_o
);

  always_comb begin
    exec_o           = '0;
    exec_o.res_id    = exec_i.id;
    exec_o.status    = rida_pkg::ST_OK;
    exec_o.cnt_wdata = rida_pkg::COUNT_ZERO;
    case (rida_pkg::op_e'(exec_i.op))
      rida_pkg::OP_ALLOC: begin
        // pop the stack first, then fall back on a fresh id
        if (exec_i.fill != '0) begin
          exec_o.pop    = 1'b1;
          exec_o.res_id = exec_i.top_id;
        end else if (!exec_i.fresh[rida_pkg::ID_BITS]) begin
          exec_o.fresh_inc = 1'b1;
          exec_o.res_id    = exec_i.fresh[rida_pkg::ID_BITS-1:0];
        end else begin
          exec_o.res_id = '0;
          exec_o.status = rida_pkg::ST_NO_IDS;
        end
      end
      rida_pkg::OP_ADDREF: begin
        // start tracking at two, otherwise count up and hold at the top
        if (exec_i.count == rida_pkg::COUNT_ZERO) begin
          exec_o.cnt_we    = 1'b1;
          exec_o.cnt_wdata = rida_pkg::COUNT_TWO;
        end else if (exec_i.count == rida_pkg::COUNT_MAX) begin
          exec_o.status = rida_pkg::ST_SATURATED;
        end else begin
          exec_o.cnt_we    = 1'b1;
          exec_o.cnt_wdata = exec_i.count + rida_pkg::COUNT_ONE;
        end
      end
      rida_pkg::OP_RELEASE: begin
        if (exec_i.count > rida_pkg::COUNT_ONE) begin
          // still referenced: just count down
          exec_o.cnt_we    = 1'b1;
          exec_o.cnt_wdata = exec_i.count - rida_pkg::COUNT_ONE;
        end else begin
          // last reference or untracked: clear and return the id
          exec_o.cnt_we    = (exec_i.count == rida_pkg::COUNT_ONE);
          exec_o.cnt_wdata = rida_pkg::COUNT_ZERO;
          if (exec_i.fill[rida_pkg::ID_BITS]) begin
            exec_o.status = rida_pkg::ST_STACK_FULL;
          end else begin
            exec_o.push  = 1'b1;
            exec_o.freed = 1'b1;
          end
        end
      end
      default: begin
        // unused code: echo the id, change nothing
        exec_o.res_id = exec_i.id;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sim/refcounted_id_allocator_test.sv =====
// Self-checking testbench for the reference-counted ID allocator on its stream ports.
`timescale 1ns / 1ps
module refcounted_id_allocator_test;

  // The block takes code 3 on its operation field and must leave state alone
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PEND_DEPTH = 64;
  localparam int KEEP_IDS   = 48;

  typedef struct packed {
    logic [rida_pkg::ID_BITS-1:0] res_id;
    logic                         freed;
    rida_pkg::status_e            status;
  } result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_valid;
  logic [rida_pkg::TDATA_W-1:0] s_tdata;   // id, zero fill
  logic [1:0]                   s_tuser;   // operation
  logic                         s_axis_tready_o;
  logic                         m_axis_tvalid_o;
  logic                         m_ready;
  logic [rida_pkg::TDATA_W-1:0] m_axis_tdata_o;  // result_id, zero fill
  logic [2:0]                   m_axis_tuser_o;  // id_freed, status

  // Predicted allocator state
  logic [rida_pkg::ID_BITS:0]      next_fresh;
  logic [rida_pkg::ID_BITS:0]      free_depth;
  logic [rida_pkg::ID_BITS-1:0]    free_ids [rida_pkg::ID_SPACE];
  logic [rida_pkg::COUNT_BITS-1:0] ref_count [rida_pkg::ID_SPACE];

  // Predicted words in flight, oldest at pend_rd
  result_t                      pending_results [PEND_DEPTH];
  int                           pend_wr;
  int                           pend_rd;
  // Recently granted IDs, reused as operands
  logic [rida_pkg::ID_BITS-1:0] granted_ids [KEEP_IDS];
  int                           granted_wr;
  int                           granted_count;
  int                           mismatch_count;
  int                           gap_pct;
  int                           stall_pct;

  refcounted_id_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Advance the predicted state by one request and return the word it produces
  function automatic result_t apply_request(input logic [1:0] op,
                                            input logic [rida_pkg::ID_BITS-1:0] id);
    result_t                         r;
    logic [rida_pkg::COUNT_BITS-1:0] cnt;
    r.res_id = id;
    r.freed  = 1'b0;
    r.status = rida_pkg::ST_OK;
    cnt      = ref_count[id];
    case (op)
      rida_pkg::OP_ALLOC: begin
        if (free_depth != 0) begin
          free_depth = free_depth - 1'b1;
          r.res_id   = free_ids[free_depth[rida_pkg::ID_BITS-1:0]];
        end else if (next_fresh < rida_pkg::ID_SPACE) begin
          r.res_id   = next_fresh[rida_pkg::ID_BITS-1:0];
          next_fresh = next_fresh + 1'b1;
        end else begin
          r.res_id = '0;
          r.status = rida_pkg::ST_NO_IDS;
        end
      end
      rida_pkg::OP_ADDREF: begin
        if (cnt == rida_pkg::COUNT_ZERO) ref_count[id] = rida_pkg::COUNT_TWO;
        else if (cnt == rida_pkg::COUNT_MAX) r.status = rida_pkg::ST_SATURATED;
        else ref_count[id] = cnt + 1'b1;
      end
      rida_pkg::OP_RELEASE: begin
        // Other references remain: just drop one
        if (cnt > rida_pkg::COUNT_ONE) begin
          ref_count[id] = cnt - 1'b1;
        end else begin
          ref_count[id] = rida_pkg::COUNT_ZERO;
          if (free_depth == rida_pkg::ID_SPACE) begin
            r.status = rida_pkg::ST_STACK_FULL;
          end else begin
            free_ids[free_depth[rida_pkg::ID_BITS-1:0]] = id;
            free_depth = free_depth + 1'b1;
            r.freed    = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [rida_pkg::ID_BITS-1:0] random_id();
    return rida_pkg::ID_BITS'($urandom_range(0, rida_pkg::ID_SPACE - 1));
  endfunction

  // Queue a predicted word behind the ones in flight
  function automatic void pending_add(input result_t r);
    pending_results[pend_wr % PEND_DEPTH] = r;
    pend_wr++;
  endfunction

  // Keep the last granted IDs for later operands
  function automatic void remember_grant(input logic [rida_pkg::ID_BITS-1:0] id);
    granted_ids[granted_wr] = id;
    granted_wr = (granted_wr + 1) % KEEP_IDS;
    if (granted_count < KEEP_IDS) granted_count++;
  endfunction

  // Offer one word, wait for the handshake, record its prediction
  task automatic send_word(input logic [1:0] op, input logic [rida_pkg::ID_BITS-1:0] id);
    result_t want;
    int      gap;
    s_valid <= 1'b1;
    s_tuser <= op;
    s_tdata <= rida_pkg::TDATA_W'(id);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    want = apply_request(op, id);
    pending_add(want);
    if (op == rida_pkg::OP_ALLOC && want.status == rida_pkg::ST_OK) begin
      remember_grant(want.res_id);
    end
    gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
    // A zero gap keeps valid high for the next word
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid before any pause that is not part of a send
  task automatic idle_input();
    s_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    idle_input();
    while (pend_wr != pend_rd) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected id=%0d freed=%0b status=%0d, got id=%0d freed=%0b status=%0d",
               $realtime, what, want.res_id, want.freed, want.status,
               got.res_id, got.freed, got.status);
  endtask

  // Check each result word against the oldest prediction; stall at random
  initial begin : result_monitor
    result_t want;
    result_t got;
    int      stall_left;
    stall_left = 0;
    m_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_ready) begin
        got.res_id = m_axis_tdata_o[rida_pkg::ID_BITS-1:0];
        got.freed  = m_axis_tuser_o[0];
        got.status = rida_pkg::status_e'(m_axis_tuser_o[2:1]);
        if (pend_wr == pend_rd) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_results[pend_rd % PEND_DEPTH];
          pend_rd++;
          if (got.res_id !== want.res_id || got.freed !== want.freed ||
              got.status !== want.status)
            note_mismatch("result mismatch", want, got);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = pick_gap();
      end
    end
  end

  // Field extremes, every operation, untracked and repeated releases
  task automatic test_directed();
    send_word(OP_UNUSED, '0);
    send_word(OP_UNUSED, '1);
    send_word(rida_pkg::OP_ALLOC, '1);
    send_word(rida_pkg::OP_ALLOC, '0);
    send_word(rida_pkg::OP_ADDREF, '1);
    send_word(rida_pkg::OP_ADDREF, '1);
    send_word(rida_pkg::OP_RELEASE, '1);
    send_word(rida_pkg::OP_RELEASE, '1);
    send_word(rida_pkg::OP_RELEASE, '1);
    send_word(rida_pkg::OP_RELEASE, '0);
    send_word(rida_pkg::OP_RELEASE, '0);
    send_word(rida_pkg::OP_ALLOC, 10'h2AA);
    send_word(rida_pkg::OP_ALLOC, 10'h155);
    send_word(rida_pkg::OP_ALLOC, '0);
    send_word(rida_pkg::OP_ALLOC, '1);
    send_word(rida_pkg::OP_ADDREF, 10'h2AA);
    send_word(rida_pkg::OP_ADDREF, 10'h155);
    send_word(rida_pkg::OP_RELEASE, 10'h2AA);
    send_word(rida_pkg::OP_RELEASE, 10'h2AA);
    send_word(rida_pkg::OP_RELEASE, 10'h155);
    send_word(OP_UNUSED, 10'h155);
    send_word(rida_pkg::OP_ALLOC, 10'h2AA);
  endtask

  // Count up to the ceiling, push past it, then step back down a few references
  task automatic test_saturation();
    logic [rida_pkg::ID_BITS-1:0] id;
    id = random_id();
    while (ref_count[id] != rida_pkg::COUNT_MAX) send_word(rida_pkg::OP_ADDREF, id);
    repeat (3) send_word(rida_pkg::OP_ADDREF, id);
    repeat (4) send_word(rida_pkg::OP_RELEASE, id);
    send_word(rida_pkg::OP_ADDREF, id);
  endtask

  // Allocate / share / release traffic with random content and some noise
  task automatic test_random(input int n_items);
    int                           pick;
    logic [1:0]                   op;
    logic [rida_pkg::ID_BITS-1:0] id;
    for (int i = 0; i < n_items; i++) begin
      // Rotate through quiet, moderate and heavily stalled stretches
      if (i % 120 < 24) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if (i % 120 < 72) begin
        gap_pct = 30;
        stall_pct = 30;
      end else begin
        gap_pct = 10;
        stall_pct = 55;
      end
      if (i == n_items / 2) wait_drained();
      pick = $urandom_range(0, 99);
      if (granted_count != 0 && pick < 75)
        id = granted_ids[$urandom_range(0, granted_count - 1)];
      else if (pick < 82)
        id = ($urandom_range(0, 1) != 0) ? '1 : '0;
      else
        id = random_id();
      pick = $urandom_range(0, 99);
      if (pick < 30) op = rida_pkg::OP_ALLOC;
      else if (pick < 58) op = rida_pkg::OP_ADDREF;
      else if (pick < 94) op = rida_pkg::OP_RELEASE;
      else op = OP_UNUSED;
      send_word(op, id);
    end
  endtask

  // Empty the stack, use up every fresh ID, then ask for more
  task automatic test_exhaustion();
    gap_pct = 20;
    stall_pct = 20;
    while (free_depth != 0) send_word(rida_pkg::OP_ALLOC, random_id());
    while (next_fresh < rida_pkg::ID_SPACE) send_word(rida_pkg::OP_ALLOC, random_id());
    repeat (3) send_word(rida_pkg::OP_ALLOC, random_id());
    // A release then frees an ID again, unless that ID is still shared
    send_word(rida_pkg::OP_RELEASE, random_id());
    repeat (2) send_word(rida_pkg::OP_ALLOC, random_id());
  endtask

  // Fill the free stack to the top, release into it once full, then pop some
  task automatic test_stack_full();
    while (free_depth < rida_pkg::ID_SPACE) send_word(rida_pkg::OP_RELEASE, random_id());
    repeat (4) send_word(rida_pkg::OP_RELEASE, random_id());
    send_word(rida_pkg::OP_RELEASE, '1);
    repeat (20) send_word(rida_pkg::OP_ALLOC, random_id());
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("refcounted_id_allocator_test: PASS");
    else
      $display("refcounted_id_allocator_test: FAIL");
    $finish;
  endtask

  initial begin : main_sequence
    rst_ni  <= 1'b0;
    s_valid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    mismatch_count = 0;
    pend_wr = 0;
    pend_rd = 0;
    granted_wr = 0;
    granted_count = 0;
    gap_pct = 25;
    stall_pct = 25;
    next_fresh = '0;
    free_depth = '0;
    foreach (free_ids[k]) free_ids[k] = '0;
    foreach (ref_count[k]) ref_count[k] = rida_pkg::COUNT_ZERO;
    foreach (granted_ids[k]) granted_ids[k] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_saturation();
    test_random(240);
    test_exhaustion();
    test_stack_full();
    test_random(60);
    finish_run();
  end

  // Hard stop if the block hangs
  initial begin : run_limit
    #50ms;
    $display("refcounted_id_allocator_test: FAIL");
    $finish;
  end

endmodule
